### rtl/ccpt_pkg.sv
`default_nettype none
package ccpt_pkg;

  localparam int SAMPLE_WIDTH = 18;
  localparam int COEF_WIDTH = 21;
  localparam int FRAC_BITS = 16;
  localparam int CLAMP_WIDTH = 32;
  localparam int IDX_WIDTH = 5;
  localparam int TABLE_DEPTH = 24;
  localparam int TBL_IDX_W = $clog2(TABLE_DEPTH);
  localparam int NUM_CH = 3;
  localparam int NUM_TERMS = 7;
  localparam int ENABLE_WIDTH = 24;
  localparam int CFG_IDX_WIDTH = 1;
  localparam int CFG_DATA_WIDTH = ENABLE_WIDTH;
  localparam logic [ENABLE_WIDTH-1:0] ENABLE_RESET = '1;

  localparam int V_STAGES = 5;
  localparam int A_STAGES = 4;

  localparam int PROD_W = 2 * SAMPLE_WIDTH;
  localparam int V4_NAT = PROD_W + 1 - FRAC_BITS;
  localparam int V4_W = (V4_NAT > CLAMP_WIDTH) ? CLAMP_WIDTH : V4_NAT;
  localparam int PXYZ_W = V4_W + SAMPLE_WIDTH;
  localparam int V7_NAT = PXYZ_W + 1 - FRAC_BITS;
  localparam int V7_W = (V7_NAT > CLAMP_WIDTH) ? CLAMP_WIDTH : V7_NAT;
  localparam int V47_W = (V4_W > V7_W) ? V4_W : V7_W;
  localparam int VERT_W = (SAMPLE_WIDTH > V47_W) ? SAMPLE_WIDTH : V47_W;
  localparam int TERM_PROD_W = COEF_WIDTH + VERT_W;
  localparam int TERM_W = TERM_PROD_W + 1 - FRAC_BITS;
  localparam int SUM_BASE_W = (TERM_W > COEF_WIDTH) ? TERM_W : COEF_WIDTH;
  localparam int SUM_W = SUM_BASE_W + 3;

  localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (FRAC_BITS - 1);

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_LOAD   = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_TERM_ENABLES = 1'b0,
    CFG_BYPASS       = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    op_t                            op;
    logic [IDX_WIDTH-1:0]           coef_index;
    logic signed [COEF_WIDTH-1:0]   coef_value;
    logic signed [SAMPLE_WIDTH-1:0] sx;
    logic signed [SAMPLE_WIDTH-1:0] sy;
    logic signed [SAMPLE_WIDTH-1:0] sz;
  } in_item_t;

  typedef struct packed {
    op_t                            op;
    logic [IDX_WIDTH-1:0]           coef_index;
    logic signed [COEF_WIDTH-1:0]   coef_value;
    logic signed [SAMPLE_WIDTH-1:0] raw_x;
    logic signed [SAMPLE_WIDTH-1:0] raw_y;
    logic signed [SAMPLE_WIDTH-1:0] raw_z;
    logic signed [VERT_W-1:0]       v_x;
    logic signed [VERT_W-1:0]       v_y;
    logic signed [VERT_W-1:0]       v_z;
    logic signed [VERT_W-1:0]       v_xy;
    logic signed [VERT_W-1:0]       v_xz;
    logic signed [VERT_W-1:0]       v_yz;
    logic signed [VERT_W-1:0]       v_xyz;
  } vert_item_t;

  // Round half up: floor((p + half) / 2^FRAC_BITS).
  function automatic logic signed [63:0] round_q(input logic signed [63:0] p);
    return (p + ROUND_HALF) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [63:0] sat_w(input logic signed [63:0] v,
                                               input int unsigned w);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (w - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end else begin
      return v;
    end
  endfunction

endpackage
`default_nettype wire

### rtl/ccpt_coef_table.sv
`default_nettype none
module ccpt_coef_table (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [ccpt_pkg::IDX_WIDTH-1:0]           widx,
  input  logic signed [ccpt_pkg::COEF_WIDTH-1:0]   wdata,
  output logic signed [ccpt_pkg::COEF_WIDTH-1:0]   coef [ccpt_pkg::TABLE_DEPTH]
);
  import ccpt_pkg::*;

  logic signed [COEF_WIDTH-1:0] tbl_r [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we && (widx < IDX_WIDTH'(TABLE_DEPTH))) begin
      tbl_r[widx[TBL_IDX_W-1:0]] <= wdata;
    end
  end

  assign coef = tbl_r;

endmodule
`default_nettype wire

### rtl/ccpt_vertex.sv
`default_nettype none
module ccpt_vertex (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [2:0]               keep_ch,
  input  logic                     up_valid,
  output logic                     up_ready,
  input  ccpt_pkg::in_item_t       up_item,
  output logic                     dn_valid,
  input  logic                     dn_ready,
  output ccpt_pkg::vert_item_t     dn_item
);
  import ccpt_pkg::*;

  logic [V_STAGES-1:0] val_r;
  logic [V_STAGES-1:0] rdy;

  in_item_t it1_r;
  in_item_t it2_r;
  in_item_t it3_r;
  in_item_t it4_r;
  vert_item_t dn_r;

  logic signed [SAMPLE_WIDTH-1:0] m1 [NUM_CH];
  logic signed [SAMPLE_WIDTH-1:0] m2_r [NUM_CH];
  logic signed [SAMPLE_WIDTH-1:0] m3_r [NUM_CH];
  logic signed [SAMPLE_WIDTH-1:0] m4_r [NUM_CH];

  logic signed [PROD_W-1:0] pxy2_r;
  logic signed [PROD_W-1:0] pxz2_r;
  logic signed [PROD_W-1:0] pyz2_r;
  logic signed [V4_W-1:0]   vxy3_r;
  logic signed [V4_W-1:0]   vxz3_r;
  logic signed [V4_W-1:0]   vyz3_r;
  logic signed [V4_W-1:0]   vxy4_r;
  logic signed [V4_W-1:0]   vxz4_r;
  logic signed [V4_W-1:0]   vyz4_r;
  logic signed [PXYZ_W-1:0] pxyz4_r;

  always_comb begin
    rdy[V_STAGES-1] = !val_r[V_STAGES-1] || dn_ready;
    for (int k = V_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !val_r[k] || rdy[k+1];
    end
  end

  assign up_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      if (rdy[0]) begin
        val_r[0] <= up_valid;
      end
      for (int k = 1; k < V_STAGES; k++) begin
        if (rdy[k]) begin
          val_r[k] <= val_r[k-1];
        end
      end
    end
  end

  always_comb begin
    m1[0] = keep_ch[0] ? it1_r.sx : '0;
    m1[1] = keep_ch[1] ? it1_r.sy : '0;
    m1[2] = keep_ch[2] ? it1_r.sz : '0;
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && up_valid) begin
      it1_r <= up_item;
    end
    if (rdy[1] && val_r[0]) begin
      it2_r  <= it1_r;
      m2_r   <= m1;
      pxy2_r <= m1[0] * m1[1];
      pxz2_r <= m1[0] * m1[2];
      pyz2_r <= m1[1] * m1[2];
    end
    if (rdy[2] && val_r[1]) begin
      it3_r  <= it2_r;
      m3_r   <= m2_r;
      vxy3_r <= V4_W'(sat_w(round_q(64'(pxy2_r)), CLAMP_WIDTH));
      vxz3_r <= V4_W'(sat_w(round_q(64'(pxz2_r)), CLAMP_WIDTH));
      vyz3_r <= V4_W'(sat_w(round_q(64'(pyz2_r)), CLAMP_WIDTH));
    end
    if (rdy[3] && val_r[2]) begin
      it4_r   <= it3_r;
      m4_r    <= m3_r;
      vxy4_r  <= vxy3_r;
      vxz4_r  <= vxz3_r;
      vyz4_r  <= vyz3_r;
      pxyz4_r <= vxy3_r * m3_r[2];
    end
    if (rdy[4] && val_r[3]) begin
      dn_r.op         <= it4_r.op;
      dn_r.coef_index <= it4_r.coef_index;
      dn_r.coef_value <= it4_r.coef_value;
      dn_r.raw_x      <= it4_r.sx;
      dn_r.raw_y      <= it4_r.sy;
      dn_r.raw_z      <= it4_r.sz;
      dn_r.v_x        <= VERT_W'(m4_r[0]);
      dn_r.v_y        <= VERT_W'(m4_r[1]);
      dn_r.v_z        <= VERT_W'(m4_r[2]);
      dn_r.v_xy       <= VERT_W'(vxy4_r);
      dn_r.v_xz       <= VERT_W'(vxz4_r);
      dn_r.v_yz       <= VERT_W'(vyz4_r);
      dn_r.v_xyz      <= VERT_W'(sat_w(round_q(64'(pxyz4_r)), CLAMP_WIDTH));
    end
  end

  assign dn_valid = val_r[V_STAGES-1];
  assign dn_item  = dn_r;

  a_dn_hold: assert property (@(posedge clk) disable iff (!rst_n)
    dn_valid && !dn_ready |=> dn_valid && $stable(dn_item))
    else $error("Vertex output word changed while held.");

endmodule
`default_nettype wire

### rtl/ccpt_accum.sv
`default_nettype none
module ccpt_accum (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [ccpt_pkg::ENABLE_WIDTH-1:0]      term_en,
  input  logic                                   bypass,
  input  logic signed [ccpt_pkg::COEF_WIDTH-1:0] coef [ccpt_pkg::TABLE_DEPTH],
  input  logic                                   up_valid,
  output logic                                   up_ready,
  input  ccpt_pkg::vert_item_t                   up_item,
  output logic                                   dn_valid,
  input  logic                                   dn_ready,
  output logic signed [ccpt_pkg::COEF_WIDTH-1:0] res_x,
  output logic signed [ccpt_pkg::COEF_WIDTH-1:0] res_y,
  output logic signed [ccpt_pkg::COEF_WIDTH-1:0] res_z
);
  import ccpt_pkg::*;

  logic [A_STAGES-1:0] val_r;
  logic [A_STAGES-1:0] rdy;

  logic signed [VERT_W-1:0]       vert [NUM_TERMS];
  logic signed [SAMPLE_WIDTH-1:0] raw_in [NUM_CH];

  logic signed [TERM_PROD_W-1:0]  prod1_r [NUM_CH][NUM_TERMS];
  logic signed [COEF_WIDTH-1:0]   black1_r [NUM_CH];
  logic signed [SAMPLE_WIDTH-1:0] raw1_r [NUM_CH];

  logic signed [TERM_W-1:0]       term2_r [NUM_CH][NUM_TERMS];
  logic signed [COEF_WIDTH-1:0]   black2_r [NUM_CH];
  logic signed [SAMPLE_WIDTH-1:0] raw2_r [NUM_CH];

  logic signed [SUM_W-1:0]        sum_lo [NUM_CH];
  logic signed [SUM_W-1:0]        sum_hi [NUM_CH];
  logic signed [SUM_W-1:0]        lo3_r [NUM_CH];
  logic signed [SUM_W-1:0]        hi3_r [NUM_CH];
  logic signed [SAMPLE_WIDTH-1:0] raw3_r [NUM_CH];

  logic signed [SUM_W-1:0]        total [NUM_CH];
  logic signed [COEF_WIDTH-1:0]   res_r [NUM_CH];

  always_comb begin
    rdy[A_STAGES-1] = !val_r[A_STAGES-1] || dn_ready;
    for (int k = A_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !val_r[k] || rdy[k+1];
    end
  end

  assign up_ready = rdy[0];

  // Load words are consumed here: only samples travel on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      if (rdy[0]) begin
        val_r[0] <= up_valid && (up_item.op == OP_SAMPLE);
      end
      for (int k = 1; k < A_STAGES; k++) begin
        if (rdy[k]) begin
          val_r[k] <= val_r[k-1];
        end
      end
    end
  end

  always_comb begin
    vert[0] = up_item.v_x;
    vert[1] = up_item.v_y;
    vert[2] = up_item.v_z;
    vert[3] = up_item.v_xy;
    vert[4] = up_item.v_xz;
    vert[5] = up_item.v_yz;
    vert[6] = up_item.v_xyz;
    raw_in[0] = up_item.raw_x;
    raw_in[1] = up_item.raw_y;
    raw_in[2] = up_item.raw_z;
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      sum_lo[c] = SUM_W'(black2_r[c]) + SUM_W'(term2_r[c][0])
                + SUM_W'(term2_r[c][1]) + SUM_W'(term2_r[c][2]);
      sum_hi[c] = SUM_W'(term2_r[c][3]) + SUM_W'(term2_r[c][4])
                + SUM_W'(term2_r[c][5]) + SUM_W'(term2_r[c][6]);
      total[c]  = lo3_r[c] + hi3_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && up_valid) begin
      for (int c = 0; c < NUM_CH; c++) begin
        black1_r[c] <= coef[c];
        raw1_r[c]   <= raw_in[c];
        for (int k = 0; k < NUM_TERMS; k++) begin
          prod1_r[c][k] <= coef[(k + 1) * NUM_CH + c] * vert[k];
        end
      end
    end
    if (rdy[1] && val_r[0]) begin
      for (int c = 0; c < NUM_CH; c++) begin
        black2_r[c] <= black1_r[c];
        raw2_r[c]   <= raw1_r[c];
        for (int k = 0; k < NUM_TERMS; k++) begin
          term2_r[c][k] <= term_en[NUM_CH + NUM_CH * k + c] ?
                           TERM_W'(round_q(64'(prod1_r[c][k]))) : '0;
        end
      end
    end
    if (rdy[2] && val_r[1]) begin
      lo3_r  <= sum_lo;
      hi3_r  <= sum_hi;
      raw3_r <= raw2_r;
    end
    if (rdy[3] && val_r[2]) begin
      for (int c = 0; c < NUM_CH; c++) begin
        res_r[c] <= COEF_WIDTH'(sat_w(bypass ? 64'(raw3_r[c]) : 64'(total[c]),
                                      COEF_WIDTH));
      end
    end
  end

  assign dn_valid = val_r[A_STAGES-1];
  assign res_x = res_r[0];
  assign res_y = res_r[1];
  assign res_z = res_r[2];

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> val_r == '0)
    else $error("Stage valid bits not cleared by reset.");

  for (genvar k = 0; k < A_STAGES - 1; k++) begin : g_hold
    a_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
      val_r[k] && !rdy[k+1] |=> val_r[k])
      else $error("A stalled word was lost from the sum stages.");
  end

endmodule
`default_nettype wire

### rtl/color_cube_polynomial_transform_top.sv
`default_nettype none
// Channel  Handshake             Direction  Word
// in_      in_valid / in_stall   input      operation, coef_index, coef_value, in_x/y/z
// out_     out_valid / out_stall output     out_x, out_y, out_z
// cfg_     cfg_valid / cfg_ready input      cfg_index, cfg_data
//
// One word is accepted per cycle while in_stall is low; a sample word reaches the output
// through five vertex product stages and four term and sum stages.
// A load word writes the coefficient table as it leaves the vertex stages and gives no result.
// Reset clears the stage valid bits and the bypass bit and sets every term enable; the table is not cleared.
// The output register holds under out_stall and the stall travels back through the stage
// ready chain, so empty stages keep filling.
module color_cube_polynomial_transform_top (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic [0:0]                               in_operation,
  input  logic [ccpt_pkg::IDX_WIDTH-1:0]           in_coef_index,
  input  logic signed [ccpt_pkg::COEF_WIDTH-1:0]   in_coef_value,
  input  logic signed [ccpt_pkg::SAMPLE_WIDTH-1:0] in_x,
  input  logic signed [ccpt_pkg::SAMPLE_WIDTH-1:0] in_y,
  input  logic signed [ccpt_pkg::SAMPLE_WIDTH-1:0] in_z,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [ccpt_pkg::COEF_WIDTH-1:0]   out_x,
  output logic signed [ccpt_pkg::COEF_WIDTH-1:0]   out_y,
  output logic signed [ccpt_pkg::COEF_WIDTH-1:0]   out_z,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [ccpt_pkg::CFG_IDX_WIDTH-1:0]       cfg_index,
  input  logic [ccpt_pkg::CFG_DATA_WIDTH-1:0]      cfg_data
);
  import ccpt_pkg::*;

  logic [ENABLE_WIDTH-1:0] term_en_r;
  logic                    bypass_r;

  in_item_t   in_item;
  logic       v_up_ready;
  logic       v_dn_valid;
  logic       v_dn_ready;
  vert_item_t v_dn_item;
  logic       tbl_we;

  logic signed [COEF_WIDTH-1:0] coef [TABLE_DEPTH];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_en_r <= ENABLE_RESET;
      bypass_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_TERM_ENABLES: begin
          term_en_r <= cfg_data[ENABLE_WIDTH-1:0];
        end
        CFG_BYPASS: begin
          bypass_r <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    in_item.op         = op_t'(in_operation);
    in_item.coef_index = in_coef_index;
    in_item.coef_value = in_coef_value;
    in_item.sx         = in_x;
    in_item.sy         = in_y;
    in_item.sz         = in_z;
  end

  assign in_stall = !v_up_ready;

  ccpt_vertex u_vertex (
    .clk      (clk),
    .rst_n    (rst_n),
    .keep_ch  (term_en_r[2:0]),
    .up_valid (in_valid),
    .up_ready (v_up_ready),
    .up_item  (in_item),
    .dn_valid (v_dn_valid),
    .dn_ready (v_dn_ready),
    .dn_item  (v_dn_item)
  );

  // The table is written as the load word passes into the sum stages, so each
  // sample reads exactly the loads that came before it.
  assign tbl_we = v_dn_valid && v_dn_ready && (v_dn_item.op == OP_LOAD);

  ccpt_coef_table u_table (
    .clk   (clk),
    .we    (tbl_we),
    .widx  (v_dn_item.coef_index),
    .wdata (v_dn_item.coef_value),
    .coef  (coef)
  );

  ccpt_accum u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .term_en  (term_en_r),
    .bypass   (bypass_r),
    .coef     (coef),
    .up_valid (v_dn_valid),
    .up_ready (v_dn_ready),
    .up_item  (v_dn_item),
    .dn_valid (out_valid),
    .dn_ready (!out_stall),
    .res_x    (out_x),
    .res_y    (out_y),
    .res_z    (out_z)
  );

endmodule
`default_nettype wire
